// ===== rtl/core/mcjp_pkg.sv =====
// Shared types and constants for the min-cost jump path unit.
package mcjp_pkg;

  // Field widths fixed by the interface
  localparam int COST_W = 8;
  localparam int BEST_W = 14;
  localparam int JUMP_W = 7;
  localparam int POS_W  = 7;

  // Jump limit after reset
  localparam logic [JUMP_W-1:0] JUMP_RESET = 7'd1;

  // Input word: one position cost; negative marks a blocked position
  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic                     is_last;
  } in_word_t;

  // Output word: one step of the path, or a lone unreachable marker
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             final_step;
    logic             unreachable;
  } out_word_t;

endpackage

// ===== rtl/core/mcjp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mcjp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register read data every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/min_cost_jump_path_unit.sv =====
// Cheapest forward-jump path over a row of costs. Costs load one word per cycle into the
// cost memory while in_stall is low; the word flagged is_last closes the row. A backward
// pass then fills the best-cost memory from the last position to the first, scanning for
// each position the successors up to min(jump_limit, positions to the end) ahead, one
// successor read per cycle through the single read port of the best-cost memory. The path
// is then walked from position 1; each result word passes S_EMIT_RD and then waits in
// S_EMIT until the output register is free of out_stall. A blocked first or last position,
// or a row longer than MAX_LEN, yields a single unreachable word from S_FAIL once the
// output register is free. Input is stalled from the last word of a row until the final
// result word of that row has been placed in the output register.
module min_cost_jump_path_unit #(
  parameter int MAX_LEN = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mcjp_pkg::JUMP_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mcjp_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mcjp_pkg::out_word_t            out_word
);

  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 2);
  localparam int SW = ((CW > mcjp_pkg::JUMP_W) ? CW : mcjp_pkg::JUMP_W) + 1;
  localparam int BW = 1 + mcjp_pkg::BEST_W + IW;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FAIL,
    S_DP_INIT,
    S_NEXT,
    S_SCAN,
    S_WRITE,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  state_t                       state;
  logic [mcjp_pkg::JUMP_W-1:0]  jump_limit;
  logic [CW-1:0]                count;
  logic                         first_blocked;
  logic [CW-1:0]                n;
  logic [IW-1:0]                i;
  logic [CW-1:0]                s;
  logic [CW-1:0]                lim;
  logic                         rd_pend;
  logic [IW-1:0]                rd_s;
  logic                         acc_valid;
  logic [mcjp_pkg::BEST_W-1:0]  acc_cost;
  logic [IW-1:0]                acc_succ;
  logic [IW-1:0]                cur;

  // Memory ports
  logic                         cost_we;
  logic [IW-1:0]                cost_waddr;
  logic [mcjp_pkg::COST_W-1:0]  cost_rdata;
  logic                         best_we;
  logic [IW-1:0]                best_waddr;
  logic [BW-1:0]                best_wdata;
  logic [IW-1:0]                best_raddr;
  logic [BW-1:0]                best_rdata;

  // Decoded best-cost entry
  logic                         b_valid;
  logic [mcjp_pkg::BEST_W-1:0]  b_cost;
  logic [IW-1:0]                b_succ;

  logic                         in_accept;
  logic                         out_free;
  logic                         out_load;
  logic [CW-1:0]                n_next;
  logic                         last_blocked;
  logic                         head_blocked;
  logic [CW-1:0]                n_m1;
  logic [IW-1:0]                i_m1;
  logic [SW-1:0]                lim_sum;
  logic [SW-1:0]                lim_cap;
  logic                         issue;
  logic                         take;
  logic [IW:0]                  cur_p1;
  logic                         cur_final;
  logic [mcjp_pkg::BEST_W-1:0]  sum_cost;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != S_LOAD);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && ((state == S_FAIL) || (state == S_EMIT));

  // Decode best entry: {valid, cost, successor}
  assign b_valid = best_rdata[BW-1];
  assign b_cost  = best_rdata[IW +: mcjp_pkg::BEST_W];
  assign b_succ  = best_rdata[IW-1:0];

  // Row length and end checks at the last word
  assign n_next       = (count <= CW'(MAX_LEN)) ? (count + CW'(1)) : count;
  assign last_blocked = in_word.cost[mcjp_pkg::COST_W-1];
  assign head_blocked = (count == '0) ? last_blocked : first_blocked;

  // Scan window of the next position: min(i - 1 + jump_limit, n - 1)
  assign n_m1    = n - CW'(1);
  assign i_m1    = i - IW'(1);
  assign lim_sum = SW'(i_m1) + SW'(jump_limit);
  assign lim_cap = (lim_sum > SW'(n_m1)) ? SW'(n_m1) : lim_sum;

  // Scan control: issue a successor read while inside the window
  assign issue = (s <= lim);
  assign take  = rd_pend && b_valid && (!acc_valid || (b_cost < acc_cost));

  assign sum_cost  = acc_cost + mcjp_pkg::BEST_W'(cost_rdata);
  assign cur_p1    = {1'b0, cur} + (IW + 1)'(1);
  assign cur_final = (CW'(cur) == n_m1);

  // Memory port steering
  always_comb begin
    cost_we    = (state == S_LOAD) && in_accept && (count < CW'(MAX_LEN));
    cost_waddr = count[IW-1:0];

    best_we    = (state == S_DP_INIT) || (state == S_WRITE);
    best_waddr = (state == S_DP_INIT) ? n_m1[IW-1:0] : i;
    if (state == S_DP_INIT) begin
      best_wdata = {1'b1, {mcjp_pkg::BEST_W{1'b0}}, {IW{1'b0}}};
    end else if (cost_rdata[mcjp_pkg::COST_W-1] || !acc_valid) begin
      best_wdata = '0;
    end else begin
      best_wdata = {1'b1, sum_cost, acc_succ};
    end

    best_raddr = (state == S_SCAN) ? s[IW-1:0] : cur;
  end

  mcjp_ram #(
    .WIDTH (mcjp_pkg::COST_W),
    .DEPTH (MAX_LEN)
  ) u_cost_ram (
    .clk   (clk),
    .we    (cost_we),
    .waddr (cost_waddr),
    .wdata (in_word.cost),
    .raddr (i),
    .rdata (cost_rdata)
  );

  mcjp_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_LEN)
  ) u_best_ram (
    .clk   (clk),
    .we    (best_we),
    .waddr (best_waddr),
    .wdata (best_wdata),
    .raddr (best_raddr),
    .rdata (best_rdata)
  );

  // Sequencer, scan accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      jump_limit <= mcjp_pkg::JUMP_RESET;
      count      <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        jump_limit <= cfg_wdata;
      end

      // Raise the output word on a load, drop it once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_LOAD: begin
          if (in_accept) begin
            if (count == '0) begin
              first_blocked <= last_blocked;
            end
            if (in_word.is_last) begin
              count <= '0;
              n     <= n_next;
              if ((n_next > CW'(MAX_LEN)) || last_blocked || head_blocked) begin
                state <= S_FAIL;
              end else begin
                state <= S_DP_INIT;
              end
            end else begin
              count <= n_next;
            end
          end
        end

        S_FAIL: begin
          if (out_free) begin
            out_word  <= '{position: '0, final_step: 1'b1, unreachable: 1'b1};
            state     <= S_LOAD;
          end
        end

        S_DP_INIT: begin
          i     <= n_m1[IW-1:0];
          state <= S_NEXT;
        end

        S_NEXT: begin
          if (i == '0) begin
            cur   <= '0;
            state <= S_EMIT_RD;
          end else begin
            i         <= i_m1;
            s         <= CW'(i);
            lim       <= CW'(lim_cap);
            acc_valid <= 1'b0;
            rd_pend   <= 1'b0;
            state     <= S_SCAN;
          end
        end

        S_SCAN: begin
          rd_pend <= issue;
          rd_s    <= s[IW-1:0];
          if (issue) begin
            s <= s + CW'(1);
          end
          // Keep the first strictly cheaper successor
          if (take) begin
            acc_valid <= 1'b1;
            acc_cost  <= b_cost;
            acc_succ  <= rd_s;
          end
          if (!issue && !rd_pend) begin
            state <= S_WRITE;
          end
        end

        S_WRITE: begin
          state <= S_NEXT;
        end

        S_EMIT_RD: begin
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            if (!b_valid) begin
              out_word <= '{position: '0, final_step: 1'b1, unreachable: 1'b1};
              state    <= S_LOAD;
            end else begin
              out_word <= '{position: mcjp_pkg::POS_W'(cur_p1), final_step: cur_final,
                            unreachable: 1'b0};
              if (cur_final) begin
                state <= S_LOAD;
              end else begin
                cur   <= b_succ;
                state <= S_EMIT_RD;
              end
            end
          end
        end

        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // An unreachable word is always a lone, final word at position zero
  a_unreach_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.unreachable |-> out_word.final_step && (out_word.position == '0))
    else $error("unreachable word with bad position or final flag");

  // The load count never passes one beyond the row capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LEN + 1))
    else $error("load count out of range");

  // Best-cost writes stay inside the current row
  a_write_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (CW'(i) < n))
    else $error("best-cost write beyond row end");

  // The path walk stays inside the current row
  a_walk_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (CW'(cur) < n))
    else $error("path walk beyond row end");

  // The scan never runs past one beyond its window
  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (s <= lim + CW'(1)))
    else $error("scan index past window");

endmodule
